### rtl/core/tpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared types and constants of the text pattern filter: configuration
// bundle, register map, queue entry and character codes.
// ----------------------------------------------------------------------------
package tpf_pkg;

   localparam int CHAR_W       = 8;
   localparam int PAT_CHARS    = 32;
   localparam int PAT_IDX_W    = 5;
   localparam int PAT_BITS     = PAT_CHARS * CHAR_W;
   localparam int LENGTH_W     = 6;
   localparam int COUNT_W      = 9;
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;
   localparam int REG_IDX_W    = 3;
   localparam int SLOT_LSB     = 3;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_PAT_0_7   = 3'd0,
      REG_PAT_8_15  = 3'd1,
      REG_PAT_16_23 = 3'd2,
      REG_PAT_24_31 = 3'd3,
      REG_LENGTH    = 3'd4,
      REG_MODE      = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_CHAR       = 2'd0,
      OP_CLOSE      = 2'd1,
      OP_CHAR_CLOSE = 2'd2
   } op_type;

   typedef struct packed {
      logic [PAT_BITS-1:0] pattern;
      logic [LENGTH_W-1:0] length;
      logic                mode;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   text_byte;
   } entry_type;

endpackage

### rtl/core/text_pattern_filter_core.sv
`timescale 1ns / 1ps
// Result path: the closing transaction is registered in the queue, then in the result register.
// Throughput: 1 text byte per cycle while no closing byte waits on a held result, set by
// the unit state update in the back stage (window compare across all lanes, or one word step).
// Reset: synchronous, active high; clears the queue, unit state and result valid
// flag, and returns the registers to pattern zero, length one, line mode.
// ----------------------------------------------------------------------------
// text_pattern_filter_core
// Streaming line substring and word approximate subsequence filter over a
// text byte stream, with an APB-style configuration port.
// ----------------------------------------------------------------------------
module text_pattern_filter_core #(
   parameter int PATTERN_MAX = 32,
   parameter int LINE_MAX    = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tpf_pkg::CHAR_W-1:0]      req_text_byte,
   input  logic                            req_end_of_text,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_matched,
   output logic [tpf_pkg::COUNT_W-1:0]     rsp_unit_length,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tpf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tpf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tpf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   tpf_pkg::cfg_type   cfg;
   tpf_pkg::entry_type push_entry;
   tpf_pkg::entry_type head;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;

   tpf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpf_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .mode            (cfg.mode),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (push_entry)
   );

   tpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (head)
   );

   tpf_back #(
      .PATTERN_MAX (PATTERN_MAX),
      .LINE_MAX    (LINE_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_valid         (q_valid),
      .q_head          (head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_matched     (rsp_matched),
      .rsp_unit_length (rsp_unit_length)
   );

endmodule

### rtl/core/tpf_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_csr
// Configuration registers behind the APB-style port: pattern bytes, pattern
// length and match mode.
// ----------------------------------------------------------------------------
module tpf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tpf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tpf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tpf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output tpf_pkg::cfg_type                cfg
);

   logic [tpf_pkg::PAT_BITS-1:0] pattern_ff;
   logic [tpf_pkg::LENGTH_W-1:0] length_ff;
   logic                         mode_ff;
   logic                         wr_en;
   tpf_pkg::reg_index_type       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = tpf_pkg::reg_index_type'(paddr[tpf_pkg::SLOT_LSB +: tpf_pkg::REG_IDX_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= tpf_pkg::LENGTH_W'(1);
         mode_ff    <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_idx)
            tpf_pkg::REG_PAT_0_7:   pattern_ff[0*64 +: 64] <= pwdata;
            tpf_pkg::REG_PAT_8_15:  pattern_ff[1*64 +: 64] <= pwdata;
            tpf_pkg::REG_PAT_16_23: pattern_ff[2*64 +: 64] <= pwdata;
            tpf_pkg::REG_PAT_24_31: pattern_ff[3*64 +: 64] <= pwdata;
            tpf_pkg::REG_LENGTH:    length_ff <= pwdata[tpf_pkg::LENGTH_W-1:0];
            tpf_pkg::REG_MODE:      mode_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tpf_pkg::REG_PAT_0_7:   prdata = pattern_ff[0*64 +: 64];
         tpf_pkg::REG_PAT_8_15:  prdata = pattern_ff[1*64 +: 64];
         tpf_pkg::REG_PAT_16_23: prdata = pattern_ff[2*64 +: 64];
         tpf_pkg::REG_PAT_24_31: prdata = pattern_ff[3*64 +: 64];
         tpf_pkg::REG_LENGTH:    prdata = tpf_pkg::CSR_DATA_W'(length_ff);
         tpf_pkg::REG_MODE:      prdata = tpf_pkg::CSR_DATA_W'(mode_ff);
         default:                prdata = '0;
      endcase
   end

   assign cfg.pattern = pattern_ff;
   assign cfg.length  = length_ff;
   assign cfg.mode    = mode_ff;

endmodule

### rtl/core/tpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_front
// Input side: accept a text byte and classify it as a character, a unit
// delimiter or a character that also ends the text.
// ----------------------------------------------------------------------------
module tpf_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tpf_pkg::CHAR_W-1:0]    req_text_byte,
   input  logic                          req_end_of_text,
   input  logic                          mode,
   input  logic                          q_full,
   output logic                          q_push,
   output tpf_pkg::entry_type            q_entry
);

   logic is_delim;

   assign req_ready = ~q_full;
   assign q_push    = req_valid & ~q_full;

   assign is_delim = (req_text_byte == tpf_pkg::CH_NEWLINE)
                   | (mode & (req_text_byte == tpf_pkg::CH_SPACE));

   always_comb begin
      q_entry.text_byte = req_text_byte;
      priority if (is_delim) begin
         q_entry.op = tpf_pkg::OP_CLOSE;
      end else if (req_end_of_text) begin
         q_entry.op = tpf_pkg::OP_CHAR_CLOSE;
      end else begin
         q_entry.op = tpf_pkg::OP_CHAR;
      end
   end

endmodule

### rtl/core/tpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module tpf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tpf_pkg::entry_type    push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output tpf_pkg::entry_type    head
);

   tpf_pkg::entry_type mem [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/tpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_back
// Execution side: keep the unit state (recent window, line hit, word
// progress, character count) and register one result per closed non-empty unit.
// ----------------------------------------------------------------------------
module tpf_back #(
   parameter int PATTERN_MAX = 32,
   parameter int LINE_MAX    = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tpf_pkg::cfg_type               cfg,
   input  logic                           q_valid,
   input  tpf_pkg::entry_type             q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_matched,
   output logic [tpf_pkg::COUNT_W-1:0]    rsp_unit_length
);

   localparam int CountCap = (LINE_MAX < 511) ? LINE_MAX : 511;

   logic [tpf_pkg::CHAR_W-1:0]   win_ff [PATTERN_MAX];
   logic [tpf_pkg::CHAR_W-1:0]   win_in [PATTERN_MAX];
   logic                         found_ff;
   logic                         found_in;
   logic [tpf_pkg::LENGTH_W-1:0] prog_ff;
   logic [tpf_pkg::LENGTH_W-1:0] prog_in;
   logic [tpf_pkg::COUNT_W-1:0]  count_ff;
   logic [tpf_pkg::COUNT_W-1:0]  count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_matched_ff;
   logic [tpf_pkg::COUNT_W-1:0]  rsp_unit_length_ff;

   logic [tpf_pkg::LENGTH_W-1:0] n_eff;
   logic [tpf_pkg::LENGTH_W-1:0] lane_idx [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]       lane_ok;
   logic [tpf_pkg::CHAR_W-1:0]   prog_char;
   logic                         take_char;
   logic                         close_unit;
   logic                         emit;
   logic                         match_now;

   assign q_pop = q_valid & (~close_unit | ~rsp_valid_ff | rsp_ready);

   always_comb begin
      priority if (cfg.length == '0) begin
         n_eff = tpf_pkg::LENGTH_W'(1);
      end else if (cfg.length > tpf_pkg::LENGTH_W'(PATTERN_MAX)) begin
         n_eff = tpf_pkg::LENGTH_W'(PATTERN_MAX);
      end else begin
         n_eff = cfg.length;
      end
   end

   always_comb begin
      unique case (q_head.op)
         tpf_pkg::OP_CHAR: begin
            take_char  = 1'b1;
            close_unit = 1'b0;
         end
         tpf_pkg::OP_CLOSE: begin
            take_char  = 1'b0;
            close_unit = 1'b1;
         end
         tpf_pkg::OP_CHAR_CLOSE: begin
            take_char  = 1'b1;
            close_unit = 1'b1;
         end
         default: begin
            take_char  = 1'b0;
            close_unit = 1'b0;
         end
      endcase
   end

   assign prog_char = cfg.pattern[{prog_ff[tpf_pkg::PAT_IDX_W-1:0], 3'b000} +: tpf_pkg::CHAR_W];

   always_comb begin
      win_in[0] = q_head.text_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_in[k] = win_ff[k-1];
      end
      for (int k = 0; k < PATTERN_MAX; k++) begin
         lane_idx[k] = n_eff - tpf_pkg::LENGTH_W'(1) - tpf_pkg::LENGTH_W'(k);
         lane_ok[k]  = (tpf_pkg::LENGTH_W'(k) >= n_eff)
                     | (win_in[k] == cfg.pattern[{lane_idx[k][tpf_pkg::PAT_IDX_W-1:0], 3'b000}
                                                 +: tpf_pkg::CHAR_W]);
      end
   end

   always_comb begin
      count_in = count_ff;
      found_in = found_ff;
      prog_in  = prog_ff;
      if (take_char) begin
         if (count_ff < tpf_pkg::COUNT_W'(CountCap)) begin
            count_in = count_ff + tpf_pkg::COUNT_W'(1);
         end
         if (!cfg.mode) begin
            if ((count_in >= tpf_pkg::COUNT_W'(n_eff)) && (&lane_ok)) begin
               found_in = 1'b1;
            end
         end else if ((prog_ff < n_eff) && (q_head.text_byte == prog_char)) begin
            prog_in = prog_ff + tpf_pkg::LENGTH_W'(1);
         end
      end
      if (cfg.mode) begin
         match_now = ((tpf_pkg::LENGTH_W + 1)'(prog_in) + (tpf_pkg::LENGTH_W + 1)'(1))
                   >= (tpf_pkg::LENGTH_W + 1)'(n_eff);
      end else begin
         match_now = found_in;
      end
   end

   assign emit = q_pop & close_unit & (count_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            win_ff[k] <= '0;
         end
         found_ff <= 1'b0;
         prog_ff  <= '0;
         count_ff <= '0;
      end else if (q_pop) begin
         if (close_unit) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
               win_ff[k] <= '0;
            end
            found_ff <= 1'b0;
            prog_ff  <= '0;
            count_ff <= '0;
         end else begin
            if (take_char && !cfg.mode) begin
               for (int k = 0; k < PATTERN_MAX; k++) begin
                  win_ff[k] <= win_in[k];
               end
            end
            found_ff <= found_in;
            prog_ff  <= prog_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_matched_ff     <= match_now;
         rsp_unit_length_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_unit_length = rsp_unit_length_ff;

`ifndef SYNTHESIS
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_unit_length_ff != '0))
      else $error("result transaction with empty unit");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tpf_pkg::COUNT_W'(CountCap))
      else $error("unit count above cap");

   a_prog_bound: assert property (@(posedge clock) disable iff (reset)
      prog_ff <= tpf_pkg::LENGTH_W'(tpf_pkg::PAT_CHARS))
      else $error("word progress beyond pattern");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && close_unit) |=> ((count_ff == '0) && (prog_ff == '0) && !found_ff))
      else $error("unit state kept after close");
`endif

endmodule

### verif/tb_text_pattern_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_pattern_filter_core
// Self-checking testbench for the text pattern filter core. A behavioral
// predictor tracks the line window and the word scan for every accepted byte.
// Each returned transaction is compared field by field against the oldest
// predicted unit result. Directed lines and words come first. Random text
// follows under changing patterns, lengths and modes, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module tb_text_pattern_filter_core;
   import tpf_pkg::*;

   localparam int   LINE_CAP     = 256;
   localparam logic MODE_LINE    = 1'b0;
   localparam logic MODE_WORD    = 1'b1;
   localparam int   DRAIN_CYCLES = 32;
   localparam int   QUIET_LIMIT  = 1000;
   localparam int   RANDOM_ITEMS = 200;
   localparam int   PHASE_ITEMS  = 70;

   typedef struct packed {
      logic               matched;
      logic [COUNT_W-1:0] unit_length;
   } unit_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CHAR_W-1:0]     req_text_byte;
   logic                  req_end_of_text;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_matched;
   logic [COUNT_W-1:0]    rsp_unit_length;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // filter settings and unit state as the core should hold them
   logic [PAT_BITS-1:0]   pattern_cfg;
   logic [LENGTH_W-1:0]   length_cfg;
   logic                  mode_cfg;
   logic [CHAR_W-1:0]     window_bytes [PAT_CHARS];
   logic                  line_hit;
   int                    word_progress;
   int                    char_count;

   unit_result_type       expected_units [$];
   int                    error_count = 0;
   int                    quiet_cycles = 0;
   int                    receive_hold = 0;
   int                    text_sent = 0;
   bit                    gaps_off = 1'b0;

   text_pattern_filter_core #(
      .PATTERN_MAX (PAT_CHARS),
      .LINE_MAX    (LINE_CAP)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_matched     (rsp_matched),
      .rsp_unit_length (rsp_unit_length),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int active_length();
      int n;
      n = length_cfg;
      if (n == 0) n = 1;
      if (n > PAT_CHARS) n = PAT_CHARS;
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] pattern_char(input int i);
      return pattern_cfg[i*CHAR_W +: CHAR_W];
   endfunction

   function automatic bit is_delimiter(input logic [CHAR_W-1:0] c);
      return (c == CH_NEWLINE) || (mode_cfg == MODE_WORD && c == CH_SPACE);
   endfunction

   function automatic void clear_unit_state();
      foreach (window_bytes[i]) window_bytes[i] = '0;
      line_hit      = 1'b0;
      word_progress = 0;
      char_count    = 0;
   endfunction

   function automatic void close_unit();
      unit_result_type r;
      if (char_count != 0) begin
         if (mode_cfg == MODE_LINE) begin
            r.matched = line_hit;
         end else begin
            r.matched = (word_progress + 1 >= active_length());
         end
         r.unit_length = COUNT_W'(char_count);
         expected_units.push_back(r);
      end
      clear_unit_state();
   endfunction

   function automatic void absorb_char(input logic [CHAR_W-1:0] c);
      int n;
      bit hit;
      n = active_length();
      if (char_count < LINE_CAP) char_count++;
      if (mode_cfg == MODE_LINE) begin
         for (int i = PAT_CHARS - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
         window_bytes[0] = c;
         if (char_count >= n) begin
            hit = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (window_bytes[n-1-i] != pattern_char(i)) hit = 1'b0;
            end
            if (hit) line_hit = 1'b1;
         end
      end else if (word_progress < n && c == pattern_char(word_progress)) begin
         word_progress++;
      end
   endfunction

   function automatic void predict_text_byte(input logic [CHAR_W-1:0] c, input logic eot);
      if (is_delimiter(c)) begin
         close_unit();
      end else begin
         absorb_char(c);
         if (eot) close_unit();
      end
   endfunction

   function automatic void apply_register(input reg_index_type idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_PAT_0_7:   pattern_cfg[0*CSR_DATA_W +: CSR_DATA_W] = value;
         REG_PAT_8_15:  pattern_cfg[1*CSR_DATA_W +: CSR_DATA_W] = value;
         REG_PAT_16_23: pattern_cfg[2*CSR_DATA_W +: CSR_DATA_W] = value;
         REG_PAT_24_31: pattern_cfg[3*CSR_DATA_W +: CSR_DATA_W] = value;
         REG_LENGTH:    length_cfg = value[LENGTH_W-1:0];
         REG_MODE:      mode_cfg = value[0];
         default: ;
      endcase
   endfunction

   function automatic logic [PAT_BITS-1:0] pack_pattern(input string s);
      logic [PAT_BITS-1:0] p;
      p = '0;
      for (int i = 0; i < s.len() && i < PAT_CHARS; i++) p[i*CHAR_W +: CHAR_W] = s[i];
      return p;
   endfunction

   function automatic int draw_wait();
      return gaps_off ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char(input bit wide);
      return wide ? CHAR_W'($urandom_range(0, 255)) : CHAR_W'(8'h61 + $urandom_range(0, 3));
   endfunction

   function automatic logic [CHAR_W-1:0] filler_char(input bit wide);
      logic [CHAR_W-1:0] c;
      do c = pick_char(wide); while (is_delimiter(c));
      return c;
   endfunction

   task automatic send_text(input logic [CHAR_W-1:0] c, input logic eot);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      predict_text_byte(c, eot);
      text_sent++;
   endtask

   task automatic send_string(input string s, input logic eot_last);
      for (int i = 0; i < s.len(); i++) send_text(s[i], eot_last && (i == s.len() - 1));
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << SLOT_LSB;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      apply_register(idx, value);
   endtask

   task automatic csr_release();
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_filter(input logic [PAT_BITS-1:0] pat, input int len, input logic mode);
      csr_write(REG_PAT_0_7,   pat[0*CSR_DATA_W +: CSR_DATA_W]);
      csr_write(REG_PAT_8_15,  pat[1*CSR_DATA_W +: CSR_DATA_W]);
      csr_write(REG_PAT_16_23, pat[2*CSR_DATA_W +: CSR_DATA_W]);
      csr_write(REG_PAT_24_31, pat[3*CSR_DATA_W +: CSR_DATA_W]);
      csr_write(REG_LENGTH,    CSR_DATA_W'(len));
      csr_write(REG_MODE,      CSR_DATA_W'(mode));
      csr_release();
   endtask

   // hold until every unit result is back, then let queued bytes retire
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_unit(input bit wide);
      int n;
      int roll;
      logic [CHAR_W-1:0] c;
      n = active_length();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) send_text(pick_char(1'b1), $urandom_range(0, 7) == 0);
         return;
      end
      if (mode_cfg == MODE_LINE) begin
         repeat ($urandom_range(0, 4)) send_text(filler_char(wide), 1'b0);
         if ($urandom_range(0, 2) != 0) begin
            for (int i = 0; i < n; i++) begin
               c = pattern_char(i);
               if ($urandom_range(0, 9) == 0) c = filler_char(wide);
               send_text(c, 1'b0);
            end
         end
         repeat ($urandom_range(0, 4)) send_text(filler_char(wide), 1'b0);
      end else begin
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 6) != 0) send_text(pattern_char(i), 1'b0);
            if ($urandom_range(0, 3) == 0) send_text(filler_char(wide), 1'b0);
         end
      end
      roll = $urandom_range(0, 7);
      if (roll == 0) begin
         send_text(filler_char(wide), 1'b1);
      end else if (roll == 1) begin
         send_text(CH_NEWLINE, 1'b1);
      end else if (mode_cfg == MODE_WORD && roll < 5) begin
         send_text(CH_SPACE, 1'b0);
      end else begin
         send_text(CH_NEWLINE, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) send_text(CH_NEWLINE, 1'b0);
   endtask

   task automatic test_reset_defaults();
      send_text(8'h00, 1'b0);
      send_text(CH_NEWLINE, 1'b0);
      send_text("a", 1'b0);
      send_text(CH_NEWLINE, 1'b1);
      drain();
   endtask

   task automatic test_line_substring();
      load_filter(pack_pattern("abc"), 3, MODE_LINE);
      send_string("xa cabcx\n", 1'b0);
      send_string("ab\n", 1'b0);
      send_text(CH_NEWLINE, 1'b0);
      send_string("abc", 1'b1);
      send_text("q", 1'b0);
      send_text(CH_NEWLINE, 1'b1);
      send_text(8'hFF, 1'b0);
      send_text(8'h00, 1'b1);
      drain();
   endtask

   task automatic test_word_subsequence();
      load_filter(pack_pattern("abcd"), 4, MODE_WORD);
      send_string("axbc ", 1'b0);
      send_string("ab\n", 1'b0);
      send_text(CH_SPACE, 1'b0);
      send_text("x", 1'b0);
      send_text(CH_SPACE, 1'b1);
      send_string("abcd", 1'b1);
      drain();
   endtask

   task automatic test_reconfig_mid_unit();
      load_filter(pack_pattern("ab"), 2, MODE_LINE);
      send_string("xa", 1'b0);
      drain();
      csr_write(REG_PAT_0_7, CSR_DATA_W'(pack_pattern("az")));
      csr_release();
      send_string("z\n", 1'b0);
      send_string("ab", 1'b0);
      drain();
      load_filter(pack_pattern("abcd"), 4, MODE_WORD);
      send_string("ab", 1'b0);
      drain();
      csr_write(REG_LENGTH, CSR_DATA_W'(3));
      csr_release();
      send_text(CH_NEWLINE, 1'b0);
      drain();
   endtask

   task automatic test_long_units();
      load_filter(pack_pattern("abc"), 3, MODE_LINE);
      repeat (300) send_text(filler_char(1'b0), 1'b0);
      send_string("abc\n", 1'b0);
      drain();
      load_filter(pack_pattern("dcba"), 4, MODE_WORD);
      repeat (280) send_text(filler_char(1'b0), 1'b0);
      send_text("d", 1'b1);
      drain();
   endtask

   task automatic test_random_text();
      int start;
      int phase_start;
      int len;
      bit wide;
      logic [PAT_BITS-1:0] pat;
      start = text_sent;
      while (text_sent - start < RANDOM_ITEMS) begin
         gaps_off = ($urandom_range(0, 3) == 0);
         wide     = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = PAT_CHARS;
            2:       len = (1 << LENGTH_W) - 1;
            3:       len = $urandom_range(0, (1 << LENGTH_W) - 1);
            default: len = $urandom_range(1, 5);
         endcase
         if ($urandom_range(0, 7) == 0) begin
            pat = '1;
         end else begin
            for (int i = 0; i < PAT_CHARS; i++) pat[i*CHAR_W +: CHAR_W] = pick_char(wide);
         end
         load_filter(pat, len, $urandom_range(0, 1) ? MODE_WORD : MODE_LINE);
         phase_start = text_sent;
         while (text_sent - phase_start < PHASE_ITEMS) send_unit(wide);
         drain();
      end
      gaps_off = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready <= (receive_hold == 0);
      if (receive_hold > 0) receive_hold = receive_hold - 1;
   end

   always @(posedge clock) begin
      unit_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         receive_hold = draw_wait();
         if (expected_units.size() == 0) begin
            error_count++;
            $display("%0t unexpected transaction: expected none, actual matched=%0b length=%0d",
                     $time, rsp_matched, rsp_unit_length);
         end else begin
            want = expected_units.pop_front();
            if (rsp_matched !== want.matched) begin
               error_count++;
               $display("%0t matched mismatch: expected %0b, actual %0b",
                        $time, want.matched, rsp_matched);
            end
            if (rsp_unit_length !== want.unit_length) begin
               error_count++;
               $display("%0t unit_length mismatch: expected %0d, actual %0d",
                        $time, want.unit_length, rsp_unit_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = '0;
      req_end_of_text = 1'b0;
      rsp_ready       = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      pattern_cfg     = '0;
      length_cfg      = LENGTH_W'(1);
      mode_cfg        = MODE_LINE;
      clear_unit_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_line_substring();
      test_word_subsequence();
      test_reconfig_mid_unit();
      test_long_units();
      test_random_text();
      drain();

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
